### hw/rtl/ils_pkg.sv
// Shared constants, codes and types for the indexed list store.
`timescale 1ns / 1ps
package ils_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic load;   // take the write value
    logic shift;  // take the right neighbor's entry
    logic wrap;   // take the head entry (rotation)
  } cell_ctl_t;

endpackage

### hw/rtl/ils_cell.sv
// One storage cell of the list chain.
`timescale 1ns / 1ps
module ils_cell #(
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  ils_pkg::cell_ctl_t ctl,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic [WIDTH-1:0]   right_data,
  input  logic [WIDTH-1:0]   head_data,
  output logic [WIDTH-1:0]   data
);
  import ils_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= wr_data;
    end else if (ctl.shift) begin
      data <= right_data;
    end else if (ctl.wrap) begin
      data <= head_data;
    end
  end

endmodule

### hw/rtl/indexed_list_store.sv
// Indexed list store: a chain of entry cells with a fill count.
//
// Input channel s_*: one item per operation. s_tuser holds op (find, write,
// delete, dump); s_tdata holds index and value. Output channel m_*: result
// items, m_tuser holds status, m_tlast marks the final result of an item.
// Write, delete and any operation on an empty store answer directly: the
// result is registered at the accepting edge and the next item is taken as
// soon as the output register is free.
// Find rotates the chain once around the filled cells, one cell compared
// at the head per cycle, result at the end.
// Dump rotates the chain the same way and emits one entry per cycle while
// the receiver takes them, count results in all.
// After either scan the chain is back in its original order.
// A new item is taken only when no scan runs and the output register is
// empty or being emptied. A stalled receiver holds the result and pauses
// the rotation.
// Reset empties the store (count zero) and clears the output valid; cell
// contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
module indexed_list_store #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF,
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // index[4:0], value[36:5], zero[39:37]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // position[3:0], element[35:4], fill_count[40:36], zero
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);
  import ils_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 5) ? CW : 5;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [IW-1:0]    step, step_next;
  logic             hit, hit_next;
  logic [IW-1:0]    where, where_next;
  logic             is_dump, is_dump_next;
  logic [WIDTH-1:0] find_val, find_val_next;

  logic [WIDTH-1:0] cell_q [DEPTH];
  cell_ctl_t        ctl [DEPTH];
  logic [WIDTH-1:0] head;

  logic [1:0]       in_op;
  logic [4:0]       in_index;
  logic [WIDTH-1:0] in_val;
  logic [CMPW-1:0]  idx_ext, cnt_ext;

  logic             accept, out_free, at_end, match;
  logic             wr_en, del_en, rot_en;
  logic             out_load;
  logic [1:0]       out_status;
  logic [3:0]       out_pos;
  logic [31:0]      out_elem;
  logic             out_last;

  assign in_op    = s_tuser;
  assign in_index = s_tdata[4:0];
  assign in_val   = WIDTH'(s_tdata[36:5]);
  assign idx_ext  = CMPW'(in_index);
  assign cnt_ext  = CMPW'(count);
  assign head     = cell_q[0];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign at_end   = (CW'(step) + CW'(1)) == count;
  assign match    = (head == find_val);

  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    hit_next      = hit;
    where_next    = where;
    is_dump_next  = is_dump;
    find_val_next = find_val;
    wr_en         = 1'b0;
    del_en        = 1'b0;
    rot_en        = 1'b0;
    out_load      = 1'b0;
    out_status    = ST_OK;
    out_pos       = 4'd0;
    out_elem      = 32'd0;
    out_last      = 1'b1;

    if (state == S_IDLE) begin
      if (accept) begin
        case (in_op)
          OP_FIND, OP_DUMP: begin
            if (count == '0) begin
              out_load   = 1'b1;
              out_status = ST_NOTFOUND;
            end else begin
              state_next    = S_SCAN;
              step_next     = '0;
              hit_next      = 1'b0;
              where_next    = '0;
              is_dump_next  = (in_op == OP_DUMP);
              find_val_next = in_val;
            end
          end
          OP_WRITE: begin
            out_load = 1'b1;
            if (idx_ext < cnt_ext) begin
              wr_en = 1'b1;
            end else if (idx_ext == cnt_ext) begin
              if (cnt_ext < CMPW'(DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end else begin
                out_status = ST_FULL;
              end
            end else begin
              out_status = ST_RANGE;
            end
          end
          OP_DELETE: begin
            out_load = 1'b1;
            if (idx_ext < cnt_ext) begin
              del_en     = 1'b1;
              count_next = count - CW'(1);
            end else begin
              out_status = ST_RANGE;
            end
          end
          default: begin
            out_load   = 1'b1;
            out_status = ST_RANGE;
          end
        endcase
      end
    end else begin
      if (is_dump) begin
        if (out_free) begin
          out_load = 1'b1;
          out_pos  = 4'(step);
          out_elem = 32'(head);
          out_last = at_end;
          rot_en   = 1'b1;
          step_next = step + IW'(1);
          if (at_end) begin
            state_next = S_IDLE;
          end
        end
      end else begin
        if (!at_end) begin
          rot_en    = 1'b1;
          step_next = step + IW'(1);
          if (match) begin
            hit_next   = 1'b1;
            where_next = step;
          end
        end else if (out_free) begin
          rot_en     = 1'b1;
          out_load   = 1'b1;
          out_status = (hit || match) ? ST_OK : ST_NOTFOUND;
          out_pos    = match ? 4'(step) : (hit ? 4'(where) : 4'd0);
          state_next = S_IDLE;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].load  = wr_en && (CMPW'(i) == idx_ext);
      ctl[i].shift = ((del_en && (CMPW'(i) >= idx_ext)) || rot_en) &&
                     (CMPW'(i + 1) < cnt_ext);
      ctl[i].wrap  = rot_en && (CMPW'(i + 1) == cnt_ext);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] right;
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_q[g];
    end else begin : g_mid
      assign right = cell_q[g + 1];
    end
    ils_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .wr_data    (in_val),
      .right_data (right),
      .head_data  (head),
      .data       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step     <= step_next;
    hit      <= hit_next;
    where    <= where_next;
    is_dump  <= is_dump_next;
    find_val <= find_val_next;
    if (out_load) begin
      m_tdata <= {7'd0, 5'(count_next), out_elem, out_pos};
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= CMPW'(DEPTH))
    else $error("fill count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scan running on an empty store");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(count))
    else $error("fill count changed during a scan");

endmodule
